>>> rtl/htfsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfsm_pkg
// Shared types, constants and helpers for the heater thermostat controller.
// ----------------------------------------------------------------------------
package htfsm_pkg;

  localparam int TEMP_W  = 10;
  localparam int BAND_W  = 8;
  localparam int HOLD_W  = 16;
  localparam int MODE_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [TEMP_W-1:0] TEMP_MAX = '1;
  localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HEAT_BELOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET_LEVEL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERHEAT_ABOVE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS     = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [TEMP_W-1:0] RST_HEAT_BELOW     = 10'd320;
  localparam logic [TEMP_W-1:0] RST_TARGET_LEVEL   = 10'd368;
  localparam logic [BAND_W-1:0] RST_BAND_WIDTH     = 8'd8;
  localparam logic [TEMP_W-1:0] RST_OVERHEAT_ABOVE = 10'd448;
  localparam logic [HOLD_W-1:0] RST_HOLD_TICKS     = 16'd5000;

  // Input item kinds.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // Mode codes as seen on the result port.
  localparam logic [MODE_W-1:0] MODE_CODE_IDLE     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CODE_HEATING  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CODE_STAB     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CODE_TARGET   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CODE_OVERHEAT = 3'd4;

  // Controller state, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_HEATING  = 5'b00010,
    ST_STAB     = 5'b00100,
    ST_TARGET   = 5'b01000,
    ST_OVERHEAT = 5'b10000
  } mode_t;

  // Configuration register set.
  typedef struct packed {
    logic [TEMP_W-1:0] heat_below;
    logic [TEMP_W-1:0] target_level;
    logic [BAND_W-1:0] band_width;
    logic [TEMP_W-1:0] overheat_above;
    logic [HOLD_W-1:0] hold_ticks;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              heater_on;
    logic              led_on;
    logic              buzzer_on;
  } result_t;

  // Map a state to its result fields.
  function automatic result_t mode_result(mode_t m);
    result_t r;
    r = '0;
    unique case (m)
      ST_HEATING: begin
        r.mode      = MODE_CODE_HEATING;
        r.heater_on = 1'b1;
      end
      ST_STAB: begin
        r.mode      = MODE_CODE_STAB;
        r.heater_on = 1'b1;
      end
      ST_TARGET: begin
        r.mode   = MODE_CODE_TARGET;
        r.led_on = 1'b1;
      end
      ST_OVERHEAT: begin
        r.mode      = MODE_CODE_OVERHEAT;
        r.led_on    = 1'b1;
        r.buzzer_on = 1'b1;
      end
      default: begin
        r.mode = MODE_CODE_IDLE;
      end
    endcase
    return r;
  endfunction

endpackage

>>> rtl/htfsm_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfsm_core
// Mode state machine and hold timer. Updates on each accepted transaction and
// presents the result of that transaction combinationally.
// ----------------------------------------------------------------------------
module htfsm_core (
  input  logic                        clk,
  input  logic                        rst,
  input  htfsm_pkg::cfg_t             cfg,
  input  logic                        item_accept,
  input  logic                        kind,
  input  logic [htfsm_pkg::TEMP_W-1:0] temperature,
  output htfsm_pkg::result_t          result
);
  import htfsm_pkg::*;

  mode_t             mode, mode_next;
  logic              hold_active, hold_active_next;
  logic [HOLD_W-1:0] hold_count, hold_count_next;

  logic [TEMP_W-1:0] band_lo;
  logic [TEMP_W-1:0] band_hi;
  logic [TEMP_W:0]   hi_sum;
  logic              in_band;
  logic              below_heat;
  logic              above_over;

  // Band bounds, saturated to the temperature range.
  always_comb begin
    hi_sum  = {1'b0, cfg.target_level} + {{(TEMP_W + 1 - BAND_W){1'b0}}, cfg.band_width};
    band_hi = hi_sum[TEMP_W] ? TEMP_MAX : hi_sum[TEMP_W-1:0];
    if (cfg.target_level > {{(TEMP_W - BAND_W){1'b0}}, cfg.band_width}) begin
      band_lo = cfg.target_level - {{(TEMP_W - BAND_W){1'b0}}, cfg.band_width};
    end else begin
      band_lo = '0;
    end
  end

  assign in_band    = (temperature >= band_lo) && (temperature <= band_hi);
  assign below_heat = temperature < cfg.heat_below;
  assign above_over = temperature > cfg.overheat_above;

  // Next state for one transaction.
  always_comb begin
    mode_next        = mode;
    hold_active_next = hold_active;
    hold_count_next  = hold_count;
    if (kind == KIND_TICK) begin
      if (hold_active && (hold_count != HOLD_MAX)) begin
        hold_count_next = hold_count + 1'b1;
      end
    end else begin
      unique case (mode)
        ST_HEATING: begin
          if (temperature >= band_lo) begin
            mode_next = ST_STAB;
          end else if (above_over) begin
            mode_next = ST_OVERHEAT;
          end
        end
        ST_STAB: begin
          if (in_band) begin
            // The timer starts from zero on the first in-band sample.
            if (!hold_active) begin
              hold_active_next = 1'b1;
              hold_count_next  = '0;
            end
            if (hold_count_next > cfg.hold_ticks) begin
              mode_next = ST_TARGET;
            end
          end else begin
            hold_active_next = 1'b0;
            hold_count_next  = '0;
            if (below_heat) begin
              mode_next = ST_HEATING;
            end else if (above_over) begin
              mode_next = ST_OVERHEAT;
            end
          end
        end
        ST_TARGET: begin
          if (temperature < band_lo) begin
            mode_next = ST_HEATING;
          end else if (above_over) begin
            mode_next = ST_OVERHEAT;
          end
        end
        ST_OVERHEAT: begin
          if (temperature < cfg.target_level) begin
            mode_next = ST_IDLE;
          end
        end
        default: begin
          mode_next = ST_IDLE;
          if (below_heat) begin
            mode_next = ST_HEATING;
          end else if (above_over) begin
            mode_next = ST_OVERHEAT;
          end
        end
      endcase
      // The hold timer only lives in Stabilizing.
      if (mode_next != ST_STAB) begin
        hold_active_next = 1'b0;
        hold_count_next  = '0;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= ST_IDLE;
      hold_active <= 1'b0;
      hold_count  <= '0;
    end else if (item_accept) begin
      mode        <= mode_next;
      hold_active <= hold_active_next;
      hold_count  <= hold_count_next;
    end
  end

  assign result = mode_result(mode_next);

  // The timer runs only while stabilizing.
  a_hold_in_stab: assert property (@(posedge clk) disable iff (rst)
    hold_active |-> (mode == ST_STAB))
    else $error("hold timer active outside stabilizing");

  // A stopped timer holds zero.
  a_hold_clear: assert property (@(posedge clk) disable iff (rst)
    !hold_active |-> (hold_count == '0))
    else $error("hold count nonzero while timer stopped");

  // A tick advances a running, unsaturated timer by one.
  a_tick_count: assert property (@(posedge clk) disable iff (rst)
    (item_accept && kind == KIND_TICK && hold_active && hold_count != HOLD_MAX)
    |=> (hold_count == $past(hold_count) + 1'b1))
    else $error("tick did not advance hold count");

  // A tick never changes the mode.
  a_tick_mode: assert property (@(posedge clk) disable iff (rst)
    (item_accept && kind == KIND_TICK) |=> (mode == $past(mode)))
    else $error("tick changed the mode");

endmodule

>>> rtl/heater_thermostat_fsm_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heater_thermostat_fsm_unit
// Five-mode heater controller driven by temperature samples and 1 ms ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries kind and temperature. A sample
//   (kind 0) moves the mode against the thresholds; a tick (kind 1) advances
//   the hold timer while stabilizing. Every input transaction yields exactly
//   one output transaction (out_valid/out_ready) with mode, heater_on, led_on
//   and buzzer_on after the update.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   one register per transaction; cfg_ready is always high. Indexes above 4
//   are ignored. Write configuration only while no result is outstanding.
// Timing:
//   Each accepted result is registered in the output register or the skid
//   entry. Throughput is one transaction per cycle while out_ready is high.
//   An output register plus one skid entry decouple the channels: when the
//   receiver stalls, one more transaction is taken before in_ready drops.
// Reset:
//   Synchronous, active high. Mode returns to idle, the hold timer clears, the
//   registers take their defaults and both result buffers empty.
// ----------------------------------------------------------------------------
module heater_thermostat_fsm_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             kind,
  input  logic [htfsm_pkg::TEMP_W-1:0]     temperature,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [htfsm_pkg::MODE_W-1:0]     mode,
  output logic                             heater_on,
  output logic                             led_on,
  output logic                             buzzer_on,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [htfsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [htfsm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import htfsm_pkg::*;

  cfg_t    cfg;
  result_t core_result;
  result_t out_data;
  result_t skid_data;
  logic    skid_valid;
  logic    in_accept;
  logic    out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign in_accept = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heat_below     <= RST_HEAT_BELOW;
      cfg.target_level   <= RST_TARGET_LEVEL;
      cfg.band_width     <= RST_BAND_WIDTH;
      cfg.overheat_above <= RST_OVERHEAT_ABOVE;
      cfg.hold_ticks     <= RST_HOLD_TICKS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HEAT_BELOW:     cfg.heat_below     <= cfg_data[TEMP_W-1:0];
        CFG_TARGET_LEVEL:   cfg.target_level   <= cfg_data[TEMP_W-1:0];
        CFG_BAND_WIDTH:     cfg.band_width     <= cfg_data[BAND_W-1:0];
        CFG_OVERHEAT_ABOVE: cfg.overheat_above <= cfg_data[TEMP_W-1:0];
        CFG_HOLD_TICKS:     cfg.hold_ticks     <= cfg_data[HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  htfsm_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .item_accept (in_accept),
    .kind        (kind),
    .temperature (temperature),
    .result      (core_result)
  );

  // Output register with one skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : core_result;
    end else if (in_accept) begin
      skid_data <= core_result;
    end
  end

  assign mode      = out_data.mode;
  assign heater_on = out_data.heater_on;
  assign led_on    = out_data.led_on;
  assign buzzer_on = out_data.buzzer_on;

  // The skid entry is only used behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds data with output empty");

  // A result stalled by the receiver keeps its payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

  // An accepted transaction with the output free shows up next cycle.
  a_accept_to_out: assert property (@(posedge clk) disable iff (rst)
    (in_accept && out_free) |=> out_valid)
    else $error("accepted transaction did not reach the output");

endmodule
